FILE: rtl/acd_pkg.sv
// Package for the ASN.1 CER token decoder: request and result types,
// parser state, phase and status codes, tag class helpers. No dependencies.
package acd_pkg;

  localparam int unsigned MaxLengthBytes = 4;

  localparam logic [4:0] TagEnd  = 5'd0;
  localparam logic [4:0] TagInt  = 5'd2;
  localparam logic [4:0] TagEnum = 5'd10;
  localparam logic [4:0] TagSeq  = 5'd16;

  typedef enum logic [2:0] {
    PhId       = 3'd0,
    PhLenFirst = 3'd1,
    PhLenMore  = 3'd2,
    PhInt      = 3'd3,
    PhStr      = 3'd4,
    PhEnd2     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadLength = 3'd1,
    StBadClass  = 3'd2,
    StBadTag    = 3'd3,
    StBadInt    = 3'd4,
    StPrimSeq   = 3'd5,
    StBadEnd    = 3'd6,
    StBadSeg    = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         content_byte;
    logic               token_done;
    logic [4:0]         tag_number;
    logic signed [31:0] value;
    logic [31:0]        bytes_used;
    status_e            status;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  token_tag;
    logic [2:0]  len_bytes_left;
    logic [31:0] len_acc;
    logic [30:0] content_left;
    logic [31:0] int_acc;
    logic [31:0] byte_cnt;
    logic        in_seg;
  } state_t;

  localparam state_t StateReset = '{
    phase:          PhId,
    token_tag:      '0,
    len_bytes_left: '0,
    len_acc:        '0,
    content_left:   '0,
    int_acc:        '0,
    byte_cnt:       '0,
    in_seg:         1'b0
  };

  function automatic logic is_string_tag(input logic [4:0] t);
    return (t == 5'd4) || (t == 5'd12) || (t >= 5'd18 && t <= 5'd21) ||
           (t >= 5'd23 && t <= 5'd30);
  endfunction

  function automatic logic is_supported(input logic [4:0] t);
    return (t == TagEnd) || (t == TagInt) || (t == TagEnum) || (t == TagSeq) ||
           is_string_tag(t);
  endfunction

endpackage

FILE: rtl/acd_step.sv
// Single-byte parser step: current state and request in, next state and
// optional result out. Purely combinational. Depends on acd_pkg.
module acd_step (
  input  acd_pkg::state_t st_i,
  input  acd_pkg::in_t    req_i,
  output acd_pkg::state_t st_o,
  output logic            res_vld_o,
  output acd_pkg::out_t   res_o
);
  import acd_pkg::*;

  function automatic state_t go_idle(input state_t s);
    state_t r;
    r                = s;
    r.phase          = PhId;
    r.in_seg         = 1'b0;
    r.len_bytes_left = '0;
    r.content_left   = '0;
    return r;
  endfunction

  state_t      cur;
  state_t      nxt;
  out_t        res;
  logic        res_vld;
  logic [7:0]  b;
  logic [4:0]  tag_id;
  logic [31:0] bc_base;
  logic [31:0] bc_new;
  logic        fail_now;
  status_e     fail_code;
  logic        len_done;
  logic        indef;
  logic [31:0] len_val;
  logic [31:0] lacc_new;
  logic [2:0]  lbl_new;
  logic [31:0] iacc_new;
  logic [30:0] cl_new;

  assign b      = req_i.data_byte;
  assign tag_id = b[4:0];

  always_comb begin
    cur       = req_i.restart ? StateReset : st_i;
    bc_base   = (cur.phase == PhId && !cur.in_seg) ? '0 : cur.byte_cnt;
    bc_new    = (&bc_base) ? bc_base : bc_base + 32'd1;
    nxt       = cur;
    nxt.byte_cnt = bc_new;
    res       = '0;
    res_vld   = 1'b0;
    fail_now  = 1'b0;
    fail_code = StOk;
    len_done  = 1'b0;
    indef     = 1'b0;
    len_val   = '0;
    lacc_new  = {cur.len_acc[23:0], b};
    lbl_new   = (cur.len_bytes_left != '0) ? cur.len_bytes_left - 3'd1 : '0;
    iacc_new  = ({1'b0, cur.content_left} == cur.len_acc) ? {{24{b[7]}}, b}
                                                          : {cur.int_acc[23:0], b};
    cl_new    = (cur.content_left != '0) ? cur.content_left - 31'd1 : '0;

    unique case (cur.phase)
      PhId: begin
        if (cur.in_seg) begin
          if (b == 8'h00) begin
            nxt.phase = PhEnd2;
          end else if (b != {3'b000, cur.token_tag}) begin
            fail_now  = 1'b1;
            fail_code = StBadSeg;
          end else begin
            nxt.len_acc = '0;
            nxt.phase   = PhLenFirst;
          end
        end else if (b[7:6] != 2'b00) begin
          fail_now  = 1'b1;
          fail_code = StBadClass;
        end else if (!is_supported(tag_id)) begin
          fail_now  = 1'b1;
          fail_code = StBadTag;
        end else if (tag_id == TagSeq && !b[5]) begin
          fail_now  = 1'b1;
          fail_code = StPrimSeq;
        end else if ((tag_id == TagInt || tag_id == TagEnum) && b[5]) begin
          fail_now  = 1'b1;
          fail_code = StBadInt;
        end else begin
          nxt.token_tag = tag_id;
          nxt.len_acc   = '0;
          nxt.phase     = PhLenFirst;
        end
      end
      PhLenFirst: begin
        if (b == 8'h80) begin
          nxt.len_acc = '0;
          len_done    = 1'b1;
          indef       = 1'b1;
        end else if (!b[7]) begin
          nxt.len_acc = {24'd0, b};
          len_val     = {24'd0, b};
          len_done    = 1'b1;
        end else if (b[6:0] > 7'(MaxLengthBytes)) begin
          fail_now  = 1'b1;
          fail_code = StBadLength;
        end else begin
          nxt.len_bytes_left = b[2:0];
          nxt.len_acc        = '0;
          nxt.phase          = PhLenMore;
        end
      end
      PhLenMore: begin
        nxt.len_acc        = lacc_new;
        nxt.len_bytes_left = lbl_new;
        if (lbl_new == '0) begin
          if (lacc_new[31]) begin
            fail_now  = 1'b1;
            fail_code = StBadLength;
          end else begin
            len_val  = lacc_new;
            len_done = 1'b1;
          end
        end
      end
      PhInt: begin
        nxt.int_acc      = iacc_new;
        nxt.content_left = cl_new;
        if (cl_new == '0) begin
          nxt                = go_idle(nxt);
          res_vld            = 1'b1;
          res.token_done     = 1'b1;
          res.tag_number     = cur.token_tag;
          res.value          = iacc_new;
          res.bytes_used     = bc_new;
        end
      end
      PhStr: begin
        nxt.content_left = cl_new;
        res_vld          = 1'b1;
        res.has_byte     = 1'b1;
        res.content_byte = b;
        res.tag_number   = cur.token_tag;
        if (cl_new == '0) begin
          nxt.phase = PhId;
          if (!cur.in_seg) begin
            nxt            = go_idle(nxt);
            res.token_done = 1'b1;
            res.bytes_used = bc_new;
          end
        end
      end
      PhEnd2: begin
        if (b != 8'h00) begin
          fail_now  = 1'b1;
          fail_code = StBadEnd;
        end else begin
          nxt            = go_idle(nxt);
          res_vld        = 1'b1;
          res.token_done = 1'b1;
          res.tag_number = cur.token_tag;
          res.bytes_used = bc_new;
        end
      end
      default: begin
        nxt = go_idle(nxt);
      end
    endcase

    // length complete: dispatch on token kind
    if (len_done) begin
      if (cur.in_seg) begin
        if (indef) begin
          fail_now  = 1'b1;
          fail_code = StBadSeg;
        end else if (len_val == '0) begin
          nxt.phase = PhId;
        end else begin
          nxt.content_left = len_val[30:0];
          nxt.phase        = PhStr;
        end
      end else if (cur.token_tag == TagEnd) begin
        if (indef || len_val != '0) begin
          fail_now  = 1'b1;
          fail_code = StBadEnd;
        end else begin
          nxt            = go_idle(nxt);
          res_vld        = 1'b1;
          res.token_done = 1'b1;
          res.bytes_used = bc_new;
        end
      end else if (cur.token_tag == TagSeq) begin
        nxt            = go_idle(nxt);
        res_vld        = 1'b1;
        res.token_done = 1'b1;
        res.tag_number = TagSeq;
        res.value      = indef ? -32'sd1 : len_val;
        res.bytes_used = bc_new;
      end else if (cur.token_tag == TagInt || cur.token_tag == TagEnum) begin
        if (indef || len_val == '0 || len_val > 32'd4) begin
          fail_now  = 1'b1;
          fail_code = StBadInt;
        end else begin
          nxt.content_left = len_val[30:0];
          nxt.int_acc      = '0;
          nxt.phase        = PhInt;
        end
      end else if (indef) begin
        nxt.in_seg = 1'b1;
        nxt.phase  = PhId;
      end else if (len_val == '0) begin
        nxt            = go_idle(nxt);
        res_vld        = 1'b1;
        res.token_done = 1'b1;
        res.tag_number = cur.token_tag;
        res.bytes_used = bc_new;
      end else begin
        nxt.content_left = len_val[30:0];
        nxt.phase        = PhStr;
      end
    end

    if (fail_now) begin
      nxt            = go_idle(nxt);
      res_vld        = 1'b1;
      res            = '0;
      res.token_done = 1'b1;
      res.bytes_used = bc_new;
      res.status     = fail_code;
    end
  end

  assign st_o      = nxt;
  assign res_vld_o = res_vld;
  assign res_o     = res;

endmodule

FILE: rtl/asn1_cer_token_decoder.sv
// Top level of the ASN.1 CER token decoder: request register, parser state,
// result register. Depends on acd_pkg and acd_step.
//
//   channel | handshake                      | payload
//   in      | in_valid_i / in_ready_o        | in_data_i  (acd_pkg::in_t)
//   out     | out_valid_o / out_ready_i      | out_data_o (acd_pkg::out_t)
//
// One byte per cycle while results are not stalled; a byte is held in the
// request register, then its result is registered in the result register.
// The parser step is combinational logic between the two registers.
// Reset (rst_ni low) empties both registers and clears the parser state.
// A stalled result holds; one further request is buffered behind it.
module asn1_cer_token_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  acd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output acd_pkg::out_t  out_data_o
);
  import acd_pkg::*;

  logic   req_vld_q;
  in_t    req_q;
  state_t st_q;
  state_t st_d;
  logic   out_vld_q;
  out_t   out_q;
  logic   res_vld;
  out_t   res;
  logic   step_go;

  assign step_go    = req_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || step_go;

  acd_step u_step (
    .st_i      (st_q),
    .req_i     (req_q),
    .st_o      (st_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= StateReset;
    end else begin
      if (in_ready_o) begin
        req_vld_q <= in_valid_i;
      end
      if (step_go) begin
        st_q      <= st_d;
        out_vld_q <= res_vld;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (step_go && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: test/acd_token_check.sv
`timescale 1ns / 100ps
// Checker for the ASN.1 CER token decoder: watches both channels, predicts each
// byte's result from its own parser copy and compares. Depends on acd_pkg.
module acd_token_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  acd_pkg::in_t  req_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  input  acd_pkg::out_t res_i,
  output int            mismatches_o,
  output int            pending_o,
  output int            checked_o,
  output int            rejects_o
);
  import acd_pkg::*;

  localparam logic [31:0] StringTags = 32'h7FBC_1010;
  localparam logic [31:0] KnownTags  = StringTags | 32'h0001_0405;

  phase_e      ph;
  logic [4:0]  tok_tag;
  logic [2:0]  len_left;
  logic [31:0] len_acc;
  logic [31:0] content_left;
  logic [31:0] int_acc;
  logic [31:0] byte_cnt;
  logic        in_seg;

  logic        made;
  out_t        made_res;
  out_t        token_results[$];
  out_t        want;
  int          mism;
  int          checked;
  int          rejects;

  task automatic clear_parser();
    ph           = PhId;
    tok_tag      = '0;
    len_left     = '0;
    len_acc      = '0;
    content_left = '0;
    int_acc      = '0;
    byte_cnt     = '0;
    in_seg       = 1'b0;
  endtask

  task automatic to_idle();
    ph           = PhId;
    in_seg       = 1'b0;
    len_left     = '0;
    content_left = '0;
  endtask

  task automatic emit_result(input logic has, input logic [7:0] cb, input logic done,
                             input logic [4:0] tag, input logic [31:0] val,
                             input logic [31:0] used, input status_e st);
    made                  = 1'b1;
    made_res.has_byte     = has;
    made_res.content_byte = cb;
    made_res.token_done   = done;
    made_res.tag_number   = tag;
    made_res.value        = val;
    made_res.bytes_used   = used;
    made_res.status       = st;
  endtask

  task automatic abandon(input status_e st);
    to_idle();
    emit_result(1'b0, 8'h00, 1'b1, 5'd0, 32'd0, byte_cnt, st);
  endtask

  // Length complete: decide what the token does next.
  task automatic close_length(input logic indef);
    if (in_seg) begin
      if (indef) begin
        abandon(StBadSeg);
      end else if (len_acc == 0) begin
        ph = PhId;
      end else begin
        content_left = len_acc;
        ph = PhStr;
      end
    end else if (tok_tag == TagEnd) begin
      if (indef || len_acc != 0) begin
        abandon(StBadEnd);
      end else begin
        to_idle();
        emit_result(1'b0, 8'h00, 1'b1, TagEnd, 32'd0, byte_cnt, StOk);
      end
    end else if (tok_tag == TagSeq) begin
      to_idle();
      emit_result(1'b0, 8'h00, 1'b1, TagSeq, indef ? 32'hFFFF_FFFF : len_acc,
                  byte_cnt, StOk);
    end else if (tok_tag == TagInt || tok_tag == TagEnum) begin
      if (indef || len_acc == 0 || len_acc > 4) begin
        abandon(StBadInt);
      end else begin
        content_left = len_acc;
        int_acc = '0;
        ph = PhInt;
      end
    end else if (indef) begin
      in_seg = 1'b1;
      ph = PhId;
    end else if (len_acc == 0) begin
      to_idle();
      emit_result(1'b0, 8'h00, 1'b1, tok_tag, 32'd0, byte_cnt, StOk);
    end else begin
      content_left = len_acc;
      ph = PhStr;
    end
  endtask

  task automatic parse_byte(input in_t req);
    logic [7:0] b;
    logic [4:0] t;
    logic       fin;
    b = req.data_byte;
    t = b[4:0];
    made = 1'b0;
    made_res = '0;
    if (req.restart) clear_parser();
    if (ph == PhId && !in_seg) byte_cnt = '0;
    if (byte_cnt != 32'hFFFF_FFFF) byte_cnt++;
    case (ph)
      PhId: begin
        if (in_seg) begin
          if (b == 8'h00) begin
            ph = PhEnd2;
          end else if (b != {3'b000, tok_tag}) begin
            abandon(StBadSeg);
          end else begin
            len_acc = '0;
            ph = PhLenFirst;
          end
        end else if (b[7:6] != 2'b00) begin
          abandon(StBadClass);
        end else if (!KnownTags[t]) begin
          abandon(StBadTag);
        end else if (t == TagSeq && !b[5]) begin
          abandon(StPrimSeq);
        end else if ((t == TagInt || t == TagEnum) && b[5]) begin
          abandon(StBadInt);
        end else begin
          tok_tag = t;
          len_acc = '0;
          ph = PhLenFirst;
        end
      end
      PhLenFirst: begin
        if (b == 8'h80) begin
          len_acc = '0;
          close_length(1'b1);
        end else if (!b[7]) begin
          len_acc = {24'd0, b};
          close_length(1'b0);
        end else if (b[6:0] > MaxLengthBytes) begin
          abandon(StBadLength);
        end else begin
          len_left = b[2:0];
          len_acc = '0;
          ph = PhLenMore;
        end
      end
      PhLenMore: begin
        len_acc = {len_acc[23:0], b};
        if (len_left != 0) len_left--;
        if (len_left == 0) begin
          if (len_acc[31]) abandon(StBadLength);
          else close_length(1'b0);
        end
      end
      PhInt: begin
        if (content_left == len_acc) int_acc = {{24{b[7]}}, b};
        else int_acc = {int_acc[23:0], b};
        if (content_left != 0) content_left--;
        if (content_left == 0) begin
          to_idle();
          emit_result(1'b0, 8'h00, 1'b1, tok_tag, int_acc, byte_cnt, StOk);
        end
      end
      PhStr: begin
        if (content_left != 0) content_left--;
        fin = (content_left == 0) && !in_seg;
        if (content_left == 0) ph = PhId;
        if (fin) to_idle();
        emit_result(1'b1, b, fin, tok_tag, 32'd0, fin ? byte_cnt : 32'd0, StOk);
      end
      PhEnd2: begin
        if (b != 8'h00) begin
          abandon(StBadEnd);
        end else begin
          to_idle();
          emit_result(1'b0, 8'h00, 1'b1, tok_tag, 32'd0, byte_cnt, StOk);
        end
      end
      default: to_idle();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      token_results.delete();
      mism    = 0;
      checked = 0;
      rejects = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (token_results.size() == 0) begin
          if (mism < 10) begin
            $display("unexpected result: has=%0b byte=%02h done=%0b tag=%0d",
                     res_i.has_byte, res_i.content_byte, res_i.token_done,
                     res_i.tag_number);
            $display("                   value=%0d used=%0d st=%0d",
                     res_i.value, res_i.bytes_used, res_i.status);
          end
          mism++;
        end else begin
          want = token_results.pop_front();
          if (res_i.has_byte !== want.has_byte ||
              res_i.content_byte !== want.content_byte ||
              res_i.token_done !== want.token_done ||
              res_i.tag_number !== want.tag_number ||
              res_i.value !== want.value || res_i.bytes_used !== want.bytes_used ||
              res_i.status !== want.status) begin
            if (mism < 10) begin
              $display("result %0d: want has=%0b byte=%02h done=%0b tag=%0d value=%0d",
                       checked, want.has_byte, want.content_byte, want.token_done,
                       want.tag_number, want.value);
              $display("           want used=%0d st=%0d", want.bytes_used, want.status);
              $display("           got  has=%0b byte=%02h done=%0b tag=%0d value=%0d",
                       res_i.has_byte, res_i.content_byte, res_i.token_done,
                       res_i.tag_number, res_i.value);
              $display("           got  used=%0d st=%0d", res_i.bytes_used, res_i.status);
            end
            mism++;
          end
          if (want.status != StOk) rejects++;
          checked++;
        end
      end
      if (req_valid_i && req_ready_i) begin
        parse_byte(req_i);
        if (made) token_results = {token_results, made_res};
      end
    end
    mismatches_o <= mism;
    pending_o    <= token_results.size();
    checked_o    <= checked;
    rejects_o    <= rejects;
  end

endmodule

FILE: test/asn1_cer_token_decoder_test.sv
`timescale 1ns / 100ps
// Top of the ASN.1 CER token decoder testbench: clock, reset, byte stream with random
// gaps, result stalls, verdict. Depends on acd_pkg, acd_token_check and the decoder.
module asn1_cer_token_decoder_test;
  import acd_pkg::*;

  localparam int RandomBytes   = 1500;
  localparam int WatchdogLimit = 2000;

  // int min, enum 127, indefinite sequence, end marker, empty string,
  // segmented string, bad class, unsupported tag, primitive sequence, constructed int
  localparam logic [7:0] Opening [26] = '{
    8'h02, 8'h04, 8'h80, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h01, 8'h7F,
    8'h30, 8'h80, 8'h00, 8'h00, 8'h04, 8'h00,
    8'h24, 8'h80, 8'h04, 8'h01, 8'h41, 8'h00, 8'h00,
    8'hC2, 8'h01, 8'h10, 8'h22
  };
  localparam logic [4:0] StringTagList [14] = '{
    5'd4, 5'd12, 5'd18, 5'd19, 5'd20, 5'd21, 5'd23,
    5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
  };
  localparam logic [4:0] OddTagList [14] = '{
    5'd1, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
    5'd11, 5'd13, 5'd14, 5'd15, 5'd17, 5'd22, 5'd31
  };

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic calm        = 1'b0;

  int   mismatches;
  int   pending;
  int   checked;
  int   rejects;

  in_t  byte_stream[$];
  logic restart_next = 1'b0;

  asn1_cer_token_decoder dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  acd_token_check token_check (
    .clk_i,
    .rst_ni,
    .req_valid_i  (in_valid_i),
    .req_ready_i  (in_ready_o),
    .req_i        (in_data_i),
    .res_valid_i  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_i        (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .rejects_o    (rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input logic calm_now);
    int r;
    r = $urandom_range(0, 99);
    if (calm_now || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put(input logic [7:0] b);
    in_t req;
    req.data_byte = b;
    req.restart   = restart_next;
    restart_next  = 1'b0;
    byte_stream   = {byte_stream, req};
  endtask

  // short form if allowed and not forced long, else long form, sometimes zero-padded
  task automatic put_length(input logic [31:0] len, input logic long_form);
    int n;
    if (!long_form && len < 128) begin
      put(len[7:0]);
    end else begin
      n = (len[31:24] != 0) ? 4 : (len[23:16] != 0) ? 3 : (len[15:8] != 0) ? 2 : 1;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(n, MaxLengthBytes);
      put(8'h80 | 8'(n));
      for (int i = n - 1; i >= 0; i--) put(len[8*i +: 8]);
    end
  endtask

  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm <= !calm;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap(calm);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no request or result moved for %0d cycles", WatchdogLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [4:0]  tag;
    logic [31:0] len;
    int          pick;
    int          count;
    int          gap;
    logic        broken;

    foreach (Opening[i]) put(Opening[i]);
    while (byte_stream.size() < $size(Opening) + RandomBytes) begin
      if ($urandom_range(0, 15) == 0) restart_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        tag = $urandom_range(0, 1) ? TagInt : TagEnum;
        if ($urandom_range(0, 19) == 0) begin
          put({3'b001, tag});
        end else begin
          if ($urandom_range(0, 9) == 0) count = $urandom_range(0, 7);
          else count = $urandom_range(1, 4);
          put({3'b000, tag});
          put_length(count, $urandom_range(0, 3) == 0);
          if (count >= 1 && count <= 4) repeat (count) put(8'($urandom_range(0, 255)));
        end
      end else if (pick < 30) begin
        put({3'b001, TagSeq});
        if ($urandom_range(0, 2) == 0) begin
          put(8'h80);
        end else begin
          len = $urandom() >> $urandom_range(0, 31);
          if ($urandom_range(0, 9) != 0) len[31] = 1'b0;
          put_length(len, $urandom_range(0, 1) == 1);
        end
      end else if (pick < 35) begin
        put($urandom_range(0, 1) ? 8'h00 : 8'h20);
        if ($urandom_range(0, 4) == 0) put(8'($urandom_range(1, 255)));
        else put(8'h00);
      end else if (pick < 60) begin
        tag = StringTagList[$urandom_range(0, 13)];
        put({2'b00, 1'($urandom_range(0, 1)), tag});
        if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 40);
        else len = $urandom_range(0, 8);
        put_length(len, $urandom_range(0, 3) == 0);
        repeat (len) put(8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        // indefinite string built from segments, now and then broken
        tag = StringTagList[$urandom_range(0, 13)];
        put({2'b00, 1'($urandom_range(0, 1)), tag});
        put(8'h80);
        broken = 1'b0;
        repeat ($urandom_range(0, 3)) begin
          if (!broken) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
              put({3'b001, tag});
              broken = 1'b1;
            end else if (pick == 1) begin
              put({3'b000, tag});
              put(8'h80);
              broken = 1'b1;
            end else if (pick == 2) begin
              put({3'b000, tag ^ 5'd1});
              broken = 1'b1;
            end else begin
              put({3'b000, tag});
              len = $urandom_range(0, 5);
              put_length(len, $urandom_range(0, 3) == 0);
              repeat (len) put(8'($urandom_range(0, 255)));
            end
          end
        end
        if (!broken) begin
          put(8'h00);
          if ($urandom_range(0, 5) == 0) put(8'($urandom_range(1, 255)));
          else put(8'h00);
        end
      end else if (pick < 85) begin
        // huge string cut short by a restart
        tag = StringTagList[$urandom_range(0, 13)];
        put({2'b00, 1'($urandom_range(0, 1)), tag});
        put_length($urandom_range(1000, 32'h7FFF_FFFF), 1'b1);
        repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
        restart_next = 1'b1;
      end else if (pick < 93) begin
        put({3'b000, StringTagList[$urandom_range(0, 13)]});
        if ($urandom_range(0, 1)) begin
          put(8'($urandom_range(8'h85, 8'hFF)));
        end else begin
          put(8'h84);
          put(8'($urandom_range(8'h80, 8'hFF)));
          repeat (3) put(8'($urandom_range(0, 255)));
        end
      end else if (pick < 97) begin
        case ($urandom_range(0, 2))
          0:       put({2'($urandom_range(1, 3)), 6'($urandom_range(0, 63))});
          1:       put({2'b00, 1'($urandom_range(0, 1)), OddTagList[$urandom_range(0, 13)]});
          default: put({3'b000, TagSeq});
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) begin
          restart_next = 1'($urandom_range(0, 1));
          put(8'($urandom_range(0, 255)));
        end
        restart_next = 1'b1;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (byte_stream[i]) begin
      gap = pick_gap(calm);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= byte_stream[i];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Fed %0d stream bytes: well-formed tokens, broken forms, noise and restarts.",
             byte_stream.size());
    $display("%0d results compared, %0d of them error codes.", checked, rejects);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      if (pending != 0) $display("%0d expected results never came", pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
